>>> hw/rtl/lidb_pkg.sv
`default_nettype none

package lidb_pkg;

   // ring depth must be a power of two (slots are the low frame bits)
   localparam int RING_DEPTH = 64;
   localparam int IDX_W      = $clog2(RING_DEPTH);

   localparam int FRAME_W    = 32;
   localparam int LOC_W      = 7;
   localparam int REM_W      = 8;
   localparam int REP_BITS   = 7;
   localparam int HOLD_W     = 9;
   localparam int DELAY_W    = 6;
   localparam int TIME_W     = 8;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_INPUT_DELAY     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_INITIAL  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_INTERVAL = 2'd2;

   localparam logic [DELAY_W-1:0] DELAY_RESET    = 6'd3;
   localparam logic [TIME_W-1:0]  INITIAL_RESET  = 8'd20;
   localparam logic [TIME_W-1:0]  INTERVAL_RESET = 8'd5;

   typedef enum logic [1:0] {
      ACT_REMOTE = 2'd0,
      ACT_TICK   = 2'd1,
      ACT_PHASE  = 2'd2
   } lidb_action_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_APPLY
   } lidb_state_type;

   typedef struct packed {
      logic capture;
      logic write;
      logic read;
      logic apply;
   } lidb_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/lidb_ctrl.sv
`default_nettype none

module lidb_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output lidb_pkg::lidb_cmd_type cmd
);

   lidb_pkg::lidb_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lidb_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      out_free    = !rsp_valid_ff || rsp_tready;
      case (state_ff)
         lidb_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = lidb_pkg::S_WRITE;
            end
         end
         lidb_pkg::S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = lidb_pkg::S_READ;
         end
         lidb_pkg::S_READ: begin
            cmd.read = 1'b1;
            state_in = lidb_pkg::S_APPLY;
         end
         lidb_pkg::S_APPLY: begin
            // hold frame advance, phase reset and the output write until the output register is free
            if (out_free) begin
               cmd.apply = 1'b1;
               state_in  = lidb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lidb_pkg::S_IDLE;
         end
      endcase
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lidb_dp.sv
`default_nettype none

module lidb_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  lidb_pkg::lidb_cmd_type               cmd,
   input  wire [lidb_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire [lidb_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic [lidb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [lidb_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  wire                                  csr_we,
   input  wire [lidb_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire [lidb_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int FW = lidb_pkg::FRAME_W;
   localparam int LW = lidb_pkg::LOC_W;
   localparam int RW = lidb_pkg::REM_W;
   localparam int HW = lidb_pkg::HOLD_W;
   localparam int NB = lidb_pkg::REP_BITS;
   localparam int IW = lidb_pkg::IDX_W;
   localparam int TW = lidb_pkg::TIME_W;

   // captured word
   lidb_pkg::lidb_action_type act_ff;
   logic [FW-1:0] frame_ff;
   logic [RW-1:0] rval_ff;
   logic [LW-1:0] lctl_ff;
   logic          rep_ff;

   // configuration
   logic [lidb_pkg::DELAY_W-1:0] delay_ff;
   logic [TW-1:0] init_ff, intv_ff;

   // frame state
   logic [FW-1:0] cur_frame_ff, last_sent_ff;
   logic [LW-1:0] lprev_ff;
   logic [RW-1:0] rprev_ff;
   logic [HW-1:0] lhold_ff [NB];
   logic [HW-1:0] rhold_ff [NB];
   logic [HW-1:0] lhold_in [NB];
   logic [HW-1:0] rhold_in [NB];
   logic [lidb_pkg::RING_DEPTH-1:0] ready_ff;

   // rings
   logic [LW-1:0] local_mem  [lidb_pkg::RING_DEPTH];
   logic [RW-1:0] remote_mem [lidb_pkg::RING_DEPTH];
   logic [LW-1:0] lrd_ff;
   logic [RW-1:0] rrd_ff;

   // send capture
   logic          sendv_ff;
   logic [FW-1:0] sendf_ff;
   logic [LW-1:0] sendd_ff;

   logic [FW-1:0] target;
   logic          do_send;
   logic [IW-1:0] cs;
   logic          adv;
   logic [LW-1:0] rl, fl, lrep, pl;
   logic [RW-1:0] rr, fr, pr;
   logic [NB-1:0] rrep;
   logic [HW-1:0] top, lc, rc;

   assign target  = cur_frame_ff + {{(FW-lidb_pkg::DELAY_W){1'b0}}, delay_ff};
   assign do_send = (act_ff == lidb_pkg::ACT_TICK) && (target != last_sent_ff);
   assign cs      = cur_frame_ff[IW-1:0];
   assign adv     = (act_ff == lidb_pkg::ACT_TICK) && ready_ff[cs];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= lidb_pkg::lidb_action_type'(req_tuser);
         frame_ff <= req_tdata[FW-1:0];
         rval_ff  <= req_tdata[FW+RW-1:FW];
         lctl_ff  <= req_tdata[FW+RW+LW-1:FW+RW];
         rep_ff   <= req_tdata[FW+RW+LW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= lidb_pkg::DELAY_RESET;
         init_ff  <= lidb_pkg::INITIAL_RESET;
         intv_ff  <= lidb_pkg::INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            lidb_pkg::CSR_INPUT_DELAY:     delay_ff <= csr_wdata[lidb_pkg::DELAY_W-1:0];
            lidb_pkg::CSR_REPEAT_INITIAL:  init_ff  <= csr_wdata[TW-1:0];
            lidb_pkg::CSR_REPEAT_INTERVAL: intv_ff  <= csr_wdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && do_send) begin
         local_mem[target[IW-1:0]] <= lctl_ff;
      end
      if (cmd.write && act_ff == lidb_pkg::ACT_REMOTE) begin
         remote_mem[frame_ff[IW-1:0]] <= rval_ff;
      end
      if (cmd.read) begin
         lrd_ff <= local_mem[cs];
         rrd_ff <= remote_mem[cs];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         sendv_ff <= do_send;
         sendf_ff <= do_send ? target : '0;
         sendd_ff <= do_send ? lctl_ff : '0;
      end
   end

   // edges and auto-repeat
   always_comb begin
      rl   = lrd_ff & ~lprev_ff;
      fl   = lprev_ff & ~lrd_ff;
      rr   = rrd_ff & ~rprev_ff;
      fr   = rprev_ff & ~rrd_ff;
      top  = {1'b0, init_ff} + {1'b0, intv_ff};
      lrep = '0;
      rrep = '0;
      lc   = '0;
      rc   = '0;
      for (int b = 0; b < NB; b++) begin
         lc = lhold_ff[b] + HW'(1);
         if (lc >= top) begin
            lc = {1'b0, init_ff};
         end
         if (rl[b] || !lrd_ff[b]) begin
            lhold_in[b] = '0;
         end else begin
            lhold_in[b] = lc;
            lrep[b]     = (lc == {1'b0, init_ff});
         end
         rc = rhold_ff[b] + HW'(1);
         if (rc >= top) begin
            rc = {1'b0, init_ff};
         end
         if (rr[b] || !rrd_ff[b]) begin
            rhold_in[b] = '0;
         end else begin
            rhold_in[b] = rc;
            rrep[b]     = (rc == {1'b0, init_ff});
         end
      end
      pl = rl | (rep_ff ? lrep : '0);
      pr = rr | (rep_ff ? {1'b0, rrep} : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_frame_ff <= '0;
         last_sent_ff <= '1;
         lprev_ff     <= '0;
         rprev_ff     <= '0;
         ready_ff     <= '0;
         for (int b = 0; b < NB; b++) begin
            lhold_ff[b] <= '0;
            rhold_ff[b] <= '0;
         end
      end else begin
         if (cmd.write && do_send) begin
            last_sent_ff <= target;
         end
         if (cmd.write && act_ff == lidb_pkg::ACT_REMOTE) begin
            ready_ff[frame_ff[IW-1:0]] <= 1'b1;
         end
         if (cmd.apply && adv) begin
            ready_ff[cs] <= 1'b0;
            cur_frame_ff <= cur_frame_ff + FW'(1);
            lprev_ff     <= lrd_ff;
            rprev_ff     <= rrd_ff;
            if (rep_ff) begin
               for (int b = 0; b < NB; b++) begin
                  lhold_ff[b] <= lhold_in[b];
                  rhold_ff[b] <= rhold_in[b];
               end
            end
         end
         if (cmd.apply && act_ff == lidb_pkg::ACT_PHASE) begin
            lprev_ff <= '0;
            rprev_ff <= '0;
            for (int b = 0; b < NB; b++) begin
               lhold_ff[b] <= '0;
               rhold_ff[b] <= '0;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_tuser <= {adv, sendv_ff};
         rsp_tdata <= {3'b000,
                       adv ? fr : '0,
                       adv ? pr : '0,
                       adv ? fl : '0,
                       adv ? pl : '0,
                       adv ? cur_frame_ff : '0,
                       sendd_ff,
                       sendf_ff};
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/lockstep_input_delay_buffer_top.sv
`default_nettype none

// channel  dir  handshake           payload
// req      in   req_tvalid/tready   tdata 48b, tuser 2b (action)
// rsp      out  rsp_tvalid/tready   tdata 104b, tuser 2b (send_valid, advanced)
// csr      in   csr_we              csr_addr 2b, csr_wdata 8b
//
// Each word passes through capture, ring write, ring read (registered
// memory port), apply into the output register.
// The next word is taken while a result waits; apply stalls on a full output.
// Synchronous reset clears frame state and the ready flags; rings are not cleared.

module lockstep_input_delay_buffer_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // frame_number[31:0], remote_value[39:32], local_controls[46:40], repeat_enable[47]
   input  wire [lidb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // action[1:0]
   input  wire [lidb_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // send_frame[31:0], send_value[38:32], applied_frame[70:39], local_press[77:71],
   // local_release[84:78], remote_press[92:85], remote_release[100:93], zero[103:101]
   output logic [lidb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // send_valid[0], advanced[1]
   output logic [lidb_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  wire                                 csr_we,
   input  wire [lidb_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire [lidb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lidb_pkg::lidb_cmd_type cmd;

   lidb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lidb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("word accepted while busy");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |-> ##4 rsp_tvalid)
      else $error("result missing four cycles after accept");

   a_no_send_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[38:0] == '0))
      else $error("send fields not zero without send_valid");

   a_no_adv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[103:39] == '0))
      else $error("apply fields not zero without advanced");

endmodule

`default_nettype wire

>>> tb/lockstep_input_delay_buffer_top_tb.sv
`default_nettype none

module lockstep_input_delay_buffer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int LONG_HOLD        = 300;
   localparam int PHASE_WORDS      = 55;
   localparam int NUM_SETTINGS     = 8;
   localparam int RING_FILL_FRAMES = 70;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] frame;
      logic [7:0]  rval;
      logic [6:0]  lctl;
      logic        rep_en;
   } req_word_type;

   typedef struct packed {
      logic        send_valid;
      logic [31:0] send_frame;
      logic [6:0]  send_value;
      logic        advanced;
      logic [31:0] applied_frame;
      logic [6:0]  local_press;
      logic [6:0]  local_release;
      logic [7:0]  remote_press;
      logic [7:0]  remote_release;
   } outcome_type;

   typedef struct packed {
      req_word_type word;
      outcome_type  outcome;
   } queued_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [lidb_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [lidb_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [lidb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [lidb_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            csr_we = 1'b0;
   logic [lidb_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [lidb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   lockstep_input_delay_buffer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // predicted block state
   logic [lidb_pkg::LOC_W-1:0]   local_ring_m  [lidb_pkg::RING_DEPTH];
   logic [lidb_pkg::REM_W-1:0]   remote_ring_m [lidb_pkg::RING_DEPTH];
   logic                         remote_ready_m[lidb_pkg::RING_DEPTH];
   logic [lidb_pkg::FRAME_W-1:0] model_frame;
   logic [lidb_pkg::FRAME_W-1:0] model_last_sent;
   logic [lidb_pkg::LOC_W-1:0]   local_prev_m;
   logic [lidb_pkg::REM_W-1:0]   remote_prev_m;
   logic [lidb_pkg::HOLD_W-1:0]  local_hold_m [lidb_pkg::REP_BITS];
   logic [lidb_pkg::HOLD_W-1:0]  remote_hold_m[lidb_pkg::REP_BITS];
   logic [lidb_pkg::DELAY_W-1:0] cfg_delay;
   logic [lidb_pkg::TIME_W-1:0]  cfg_initial;
   logic [lidb_pkg::TIME_W-1:0]  cfg_interval;

   queued_word_type words_to_send[$];
   outcome_type     expected_outcomes[$];
   queued_word_type in_flight;
   outcome_type     rsp_want;

   int     words_pushed = 0;
   int     words_accepted = 0;
   int     errors = 0;
   int     frames_applied = 0;
   int     stall_ticks = 0;
   int     repeat_presses = 0;
   int     idle_pct = 0;
   int     gap_left = 0;
   int     stall_left = 0;
   logic   long_hold_go = 1'b0;
   logic   long_hold_done = 1'b0;
   logic [lidb_pkg::LOC_W-1:0] held_local = 7'h7f;
   logic [lidb_pkg::REM_W-1:0] held_remote = 8'hff;

   function automatic logic [lidb_pkg::HOLD_W-1:0] next_hold(
         input logic [lidb_pkg::HOLD_W-1:0] count, input logic held);
      logic [lidb_pkg::HOLD_W-1:0] c;
      logic [9:0]                  wrap_at;
      c = count + 9'd1;
      wrap_at = {2'b0, cfg_initial} + {2'b0, cfg_interval};
      if (!held) return '0;
      if ({1'b0, c} >= wrap_at) return {1'b0, cfg_initial};
      return c;
   endfunction

   function automatic outcome_type predict_outcome(input req_word_type w);
      outcome_type                  r;
      logic [lidb_pkg::FRAME_W-1:0] target;
      logic [lidb_pkg::IDX_W-1:0]   cs;
      logic [lidb_pkg::LOC_W-1:0]   cl, rl, fl, pl;
      logic [lidb_pkg::REM_W-1:0]   cr, rr, fr, pr;
      logic [lidb_pkg::HOLD_W-1:0]  h;
      logic                         held;
      int                           b;
      r = '0;
      case (w.action)
         lidb_pkg::ACT_REMOTE: begin
            remote_ring_m[w.frame[lidb_pkg::IDX_W-1:0]] = w.rval;
            remote_ready_m[w.frame[lidb_pkg::IDX_W-1:0]] = 1'b1;
         end
         lidb_pkg::ACT_PHASE: begin
            local_prev_m = '0;
            remote_prev_m = '0;
            for (b = 0; b < lidb_pkg::REP_BITS; b++) begin
               local_hold_m[b] = '0;
               remote_hold_m[b] = '0;
            end
         end
         lidb_pkg::ACT_TICK: begin
            target = model_frame
                     + {{(lidb_pkg::FRAME_W-lidb_pkg::DELAY_W){1'b0}}, cfg_delay};
            if (target != model_last_sent) begin
               local_ring_m[target[lidb_pkg::IDX_W-1:0]] = w.lctl;
               model_last_sent = target;
               r.send_valid = 1'b1;
               r.send_frame = target;
               r.send_value = w.lctl;
            end
            cs = model_frame[lidb_pkg::IDX_W-1:0];
            if (remote_ready_m[cs]) begin
               cl = local_ring_m[cs];
               cr = remote_ring_m[cs];
               rl = cl & ~local_prev_m;
               rr = cr & ~remote_prev_m;
               fl = local_prev_m & ~cl;
               fr = remote_prev_m & ~cr;
               pl = rl;
               pr = rr;
               if (w.rep_en) begin
                  for (b = 0; b < lidb_pkg::REP_BITS; b++) begin
                     held = cl[b] & ~rl[b];
                     h = next_hold(local_hold_m[b], held);
                     local_hold_m[b] = h;
                     if (held && h == {1'b0, cfg_initial}) pl[b] = 1'b1;
                     held = cr[b] & ~rr[b];
                     h = next_hold(remote_hold_m[b], held);
                     remote_hold_m[b] = h;
                     if (held && h == {1'b0, cfg_initial}) pr[b] = 1'b1;
                  end
               end
               if ((pl & ~rl) != '0 || (pr & ~rr) != '0) repeat_presses++;
               local_prev_m = cl;
               remote_prev_m = cr;
               remote_ready_m[cs] = 1'b0;
               r.advanced = 1'b1;
               r.applied_frame = model_frame;
               r.local_press = pl;
               r.local_release = fl;
               r.remote_press = pr;
               r.remote_release = fr;
               model_frame = model_frame + 32'd1;
               frames_applied++;
            end else begin
               stall_ticks++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic reset_model();
      int i;
      for (i = 0; i < lidb_pkg::RING_DEPTH; i++) begin
         local_ring_m[i] = '0;
         remote_ring_m[i] = '0;
         remote_ready_m[i] = 1'b0;
      end
      for (i = 0; i < lidb_pkg::REP_BITS; i++) begin
         local_hold_m[i] = '0;
         remote_hold_m[i] = '0;
      end
      model_frame = '0;
      model_last_sent = '1;
      local_prev_m = '0;
      remote_prev_m = '0;
      cfg_delay = lidb_pkg::DELAY_RESET;
      cfg_initial = lidb_pkg::INITIAL_RESET;
      cfg_interval = lidb_pkg::INTERVAL_RESET;
   endtask

   task automatic push_word(input logic [1:0] action, input logic [31:0] frame,
                            input logic [7:0] rval, input logic [6:0] lctl,
                            input logic rep_en);
      queued_word_type q;
      q.word.action = action;
      q.word.frame = frame;
      q.word.rval = rval;
      q.word.lctl = lctl;
      q.word.rep_en = rep_en;
      q.outcome = predict_outcome(q.word);
      words_to_send.push_back(q);
      words_pushed++;
   endtask

   task automatic push_tick(input logic [6:0] lctl, input logic rep_en);
      push_word(lidb_pkg::ACT_TICK, $urandom(), 8'($urandom_range(0, 255)), lctl, rep_en);
   endtask

   task automatic frame_pair(input logic [7:0] rval, input logic [6:0] lctl,
                             input logic rep_en);
      push_word(lidb_pkg::ACT_REMOTE, model_frame, rval, 7'($urandom_range(0, 127)),
                1'($urandom_range(0, 1)));
      push_tick(lctl, rep_en);
   endtask

   task automatic drift_controls();
      int k;
      k = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) held_local = held_local ^ (7'd1 << k);
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) held_remote = held_remote ^ (8'd1 << k);
   endtask

   task automatic random_round();
      int pick;
      pick = $urandom_range(0, 99);
      drift_controls();
      if (pick < 55) begin
         frame_pair(held_remote, held_local, $urandom_range(0, 4) != 0);
      end else if (pick < 65) begin
         push_tick(held_local, 1'($urandom_range(0, 1)));
      end else if (pick < 73) begin
         push_word(lidb_pkg::ACT_REMOTE, model_frame + $urandom_range(1, 4), held_remote,
                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (pick < 79) begin
         push_word(lidb_pkg::ACT_REMOTE, $urandom(), 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
         push_word(lidb_pkg::ACT_PHASE, $urandom(), 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
         push_word(ACT_UNUSED, $urandom(), 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else begin
         frame_pair(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_idle();
      while (words_accepted != words_pushed || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lidb_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [lidb_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lidb_pkg::CSR_INPUT_DELAY:     cfg_delay = val[lidb_pkg::DELAY_W-1:0];
         lidb_pkg::CSR_REPEAT_INITIAL:  cfg_initial = val;
         lidb_pkg::CSR_REPEAT_INTERVAL: cfg_interval = val;
         default: ;
      endcase
   endtask

   task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(in_flight.outcome);
            words_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
               gap_left = $urandom_range(0, 6);
               req_tvalid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
               in_flight = words_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {in_flight.word.rep_en, in_flight.word.lctl,
                             in_flight.word.rval, in_flight.word.frame};
               req_tuser <= in_flight.word.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (long_hold_go && !long_hold_done) begin
         long_hold_done <= 1'b1;
         stall_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            $error("result word with no outcome pending");
            errors++;
         end else begin
            rsp_want = expected_outcomes.pop_front();
            check_field("send_valid", rsp_want.send_valid, rsp_tuser[0]);
            check_field("advanced", rsp_want.advanced, rsp_tuser[1]);
            check_field("send_frame", rsp_want.send_frame, rsp_tdata[31:0]);
            check_field("send_value", rsp_want.send_value, rsp_tdata[38:32]);
            check_field("applied_frame", rsp_want.applied_frame, rsp_tdata[70:39]);
            check_field("local_press", rsp_want.local_press, rsp_tdata[77:71]);
            check_field("local_release", rsp_want.local_release, rsp_tdata[84:78]);
            check_field("remote_press", rsp_want.remote_press, rsp_tdata[92:85]);
            check_field("remote_release", rsp_want.remote_release, rsp_tdata[100:93]);
            check_field("pad", 32'd0, rsp_tdata[103:101]);
         end
      end
   end

   initial begin
      #2_500_000;
      $error("timeout: %0d outcomes still pending", expected_outcomes.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int                           p, start, f;
      bit                           paused;
      logic [lidb_pkg::DELAY_W-1:0] d;
      logic [lidb_pkg::TIME_W-1:0]  ri, rv;
      paused = 1'b0;
      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      idle_pct <= 25;

      // reset settings: no remote word reaches slot 0, so frame 0 is not made ready yet
      push_tick(7'h7f, 1'b1);
      push_tick(7'h00, 1'b0);
      push_word(lidb_pkg::ACT_REMOTE, 32'hffff_ffff, 8'hff, 7'h7f, 1'b1);
      push_word(lidb_pkg::ACT_REMOTE, 32'h8000_0002, 8'h00, 7'h00, 1'b0);
      push_word(lidb_pkg::ACT_REMOTE, 32'd3, 8'haa, 7'h55, 1'b1);
      push_word(lidb_pkg::ACT_PHASE, 32'hffff_ffff, 8'hff, 7'h7f, 1'b1);
      push_word(ACT_UNUSED, 32'hffff_ffff, 8'hff, 7'h7f, 1'b1);
      push_word(ACT_UNUSED, 32'd0, 8'h00, 7'h00, 1'b0);
      push_tick(7'h2a, 1'b1);
      wait_idle();

      // zero delay: every tick writes its own slot, filling the whole local ring
      write_csr(lidb_pkg::CSR_INPUT_DELAY, 8'd0);
      idle_pct <= 15;
      for (f = 0; f < RING_FILL_FRAMES; f++) begin
         if (f == 1) begin
            held_local = '0;
            held_remote = '0;
         end else if (f == 2) begin
            held_local = 7'h7f;
            held_remote = 8'hff;
         end else if (f > 2) begin
            drift_controls();
         end
         frame_pair(held_remote, held_local, $urandom_range(0, 9) != 0);
      end
      wait_idle();

      for (p = 0; p < NUM_SETTINGS; p++) begin
         case (p)
            0: begin d = 6'd63; ri = 8'd1;   rv = 8'd1;   end
            1: begin d = 6'd5;  ri = 8'd2;   rv = 8'd0;   end
            2: begin d = 6'd1;  ri = 8'd0;   rv = 8'd3;   end
            3: begin d = 6'd7;  ri = 8'd255; rv = 8'd255; end
            4: begin d = 6'd2;  ri = 8'd3;   rv = 8'd2;   end
            5, 6: begin
               d = 6'($urandom_range(0, 63));
               ri = 8'($urandom_range(1, 12));
               rv = 8'($urandom_range(1, 8));
            end
            default: begin
               d = lidb_pkg::DELAY_RESET;
               ri = lidb_pkg::INITIAL_RESET;
               rv = lidb_pkg::INTERVAL_RESET;
            end
         endcase
         write_csr(lidb_pkg::CSR_INPUT_DELAY, {2'b00, d});
         write_csr(lidb_pkg::CSR_REPEAT_INITIAL, ri);
         write_csr(lidb_pkg::CSR_REPEAT_INTERVAL, rv);
         if (p == 5 || p == NUM_SETTINGS - 1) idle_pct <= 0;
         else idle_pct <= (p % 2 == 0) ? 20 : 8;
         if (p == 1) long_hold_go <= 1'b1;
         start = words_pushed;
         while (words_pushed - start < PHASE_WORDS) begin
            if (p == 3 && !paused && words_pushed - start >= PHASE_WORDS / 2) begin
               wait_idle();
               paused = 1'b1;
            end
            random_round();
         end
         wait_idle();
      end

      repeat (16) @(posedge clock);
      $display("Covered %0d words under %0d settings: %0d frames applied,",
               words_pushed, NUM_SETTINGS + 2, frames_applied);
      $display("%0d stalled ticks, %0d ticks with auto-repeat, one %0d-cycle hold-off.",
               stall_ticks, repeat_presses, LONG_HOLD);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
